FILE: design/mssm_pkg.sv
// Shared types, register codes and tap helpers for the masked scan smoother.
package mssm_pkg;

    localparam int READING_W  = 24;
    localparam int TAP_W      = 16;
    localparam int K_W        = 3;
    localparam int SEQ_W      = K_W + 1;
    localparam int PROD_W     = READING_W + TAP_W;
    localparam int ACC_W      = 44;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_LOW        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_HIGH       = 2'd2;

    localparam logic [K_W-1:0]   K_RESET    = 3'd1;
    localparam logic [ACC_W-1:0] ROUND_BIAS = 44'h0000_0008_000;

    typedef struct packed {
        logic [READING_W-1:0] reading;
        logic                 reading_ok;
        logic                 scan_end;
    } in_item_t;

    typedef struct packed {
        logic [READING_W-1:0] smoothed;
        logic                 smoothed_ok;
        logic                 last_of_scan;
    } out_item_t;

    // Sequencer to window store
    typedef struct packed {
        logic push;
        logic restart;
    } win_ctrl_t;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

    // Pick tap idx out of the two packed tap words (four Q0.16 taps each)
    function automatic logic [TAP_W-1:0] tap_select(input logic [CFG_DATA_W-1:0] lo,
                                                    input logic [CFG_DATA_W-1:0] hi,
                                                    input logic [K_W-1:0]        idx);
        logic [CFG_DATA_W-1:0] w;
        w = idx[K_W-1] ? hi : lo;
        return w[{idx[1:0], 4'b0000} +: TAP_W];
    endfunction

endpackage

FILE: design/masked_symmetric_scan_smoother_core.sv
// Top level: masked symmetric scan smoother with one shared multiply-accumulate.
//
//  Channel | Ports                                    | Direction | Handshake
//  --------+------------------------------------------+-----------+----------------------
//  input   | in_valid, in_stall, in_data              | in        | valid / stall
//  output  | out_valid, out_stall, out_data           | out       | valid / stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | valid / ready
//
// Each result takes a centre read, 2K+1 taps through the shared multiplier,
// a drain of the product register and a load of the output register.
// A result with an invalid centre skips the taps and the drain.
// An item is accepted and planned before its results are made; the last ray
// of a scan yields up to 8 results at K=7.
// rst_n clears the sequencer, window flags, ray counter and taps; K resets to 1.
// in_stall stays high while an item is in work; a stalled output holds the
// sequencer in its result state until the output register frees up.
module masked_symmetric_scan_smoother_core
    import mssm_pkg::*;
#(
    parameter int MAX_NEIGHBOURS = 7,
    parameter int MAX_RAYS       = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WIN_DEPTH = 2 * MAX_NEIGHBOURS + 1;
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int POS_CAP   = (MAX_RAYS > WIN_DEPTH) ? MAX_RAYS : WIN_DEPTH;
    localparam int POS_W     = $clog2(POS_CAP + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_CENTRE,
        S_MAC,
        S_DRAIN,
        S_RESULT
    } state_t;

    state_t                  state_reg, state_next;

    logic [K_W-1:0]          k_reg;
    logic [CFG_DATA_W-1:0]   taps_lo_reg;
    logic [CFG_DATA_W-1:0]   taps_hi_reg;
    logic [K_W-1:0]          k_act;

    logic [K_W-1:0]          d_reg;
    logic [SEQ_W-1:0]        jj_reg;
    logic                    end_reg;
    logic [READING_W-1:0]    cv_reg;
    logic                    cv_ok_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic                    in_accept;
    logic                    cfg_write;
    logic                    k_write;
    logic                    out_free;
    logic                    emit_done;
    logic                    scan_done;
    logic                    has_result;
    logic [K_W-1:0]          d_plan;
    logic [POS_W-1:0]        pos_m1;

    logic [SEQ_W-1:0]        dk;
    logic [SEQ_W-1:0]        nd;
    logic [SEQ_W-1:0]        two_k;
    logic [K_W-1:0]          tap_idx;
    logic [IDX_W-1:0]        rd_idx;
    logic [READING_W-1:0]    rd_value;
    logic                    rd_ok;
    logic [POS_W-1:0]        position;
    logic [READING_W-1:0]    mac_result;

    win_ctrl_t               win_ctrl;
    mac_ctrl_t               mac_ctrl;

    // Handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign k_write   = cfg_write && (cfg_index == REG_NEIGHBOUR_COUNT);
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= K_RESET;
            taps_lo_reg <= '0;
            taps_hi_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NEIGHBOUR_COUNT: k_reg       <= cfg_data[K_W-1:0];
                REG_TAPS_LOW:        taps_lo_reg <= cfg_data;
                REG_TAPS_HIGH:       taps_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign k_act = (32'(k_reg) > MAX_NEIGHBOURS) ? K_W'(MAX_NEIGHBOURS) : k_reg;

    // Result planning: one centre K back, or on scan end all pending ones
    assign has_result = (POS_W'(k_act) < position);
    assign pos_m1     = position - 1'b1;
    assign d_plan     = (pos_m1 < POS_W'(k_act)) ? K_W'(pos_m1) : k_act;

    // Neighbour index and tap for the current step, j = jj - k
    assign dk      = SEQ_W'(d_reg) + SEQ_W'(k_act);
    assign nd      = (jj_reg > dk) ? '0 : dk - jj_reg;
    assign two_k   = {k_act, 1'b0};
    assign tap_idx = (jj_reg >= SEQ_W'(k_act)) ? K_W'(jj_reg - SEQ_W'(k_act))
                                                : K_W'(SEQ_W'(k_act) - jj_reg);
    assign rd_idx  = (state_reg == S_MAC) ? IDX_W'(nd) : IDX_W'(d_reg);

    assign emit_done = (state_reg == S_RESULT) && out_free;
    assign scan_done = emit_done && end_reg && (d_reg == '0);

    assign win_ctrl.push    = in_accept;
    assign win_ctrl.restart = k_write || scan_done;
    assign mac_ctrl.clear   = (state_reg == S_CENTRE);
    assign mac_ctrl.mul_en  = (state_reg == S_MAC);

    mssm_window #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
        .MAX_RAYS       (MAX_RAYS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .push_item (in_data),
        .rd_idx    (rd_idx),
        .rd_value  (rd_value),
        .rd_ok     (rd_ok),
        .position  (position)
    );

    mssm_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .operand (rd_ok ? rd_value : cv_reg),
        .tap     (tap_select(taps_lo_reg, taps_hi_reg, tap_idx)),
        .result  (mac_result)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                if (end_reg || has_result)
                begin
                    state_next = S_CENTRE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CENTRE:
            begin
                state_next = rd_ok ? S_MAC : S_RESULT;
            end
            S_MAC:
            begin
                if (jj_reg == two_k)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = (end_reg && d_reg != '0) ? S_CENTRE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state, centre value and registered output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            end_reg       <= 1'b0;
            d_reg         <= '0;
            jj_reg        <= '0;
            cv_reg        <= '0;
            cv_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                end_reg <= in_data.scan_end;
            end
            if (state_reg == S_PLAN)
            begin
                d_reg <= end_reg ? d_plan : k_act;
            end
            if (state_reg == S_CENTRE)
            begin
                cv_reg    <= rd_value;
                cv_ok_reg <= rd_ok;
                jj_reg    <= '0;
            end
            if (state_reg == S_MAC && jj_reg != two_k)
            begin
                jj_reg <= jj_reg + 1'b1;
            end
            if (emit_done)
            begin
                out_valid_reg             <= 1'b1;
                out_data_reg.smoothed     <= cv_ok_reg ? mac_result : '0;
                out_data_reg.smoothed_ok  <= cv_ok_reg;
                out_data_reg.last_of_scan <= end_reg && (d_reg == '0);
                if (end_reg && d_reg != '0)
                begin
                    d_reg <= d_reg - 1'b1;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("output loaded outside the result state");

    a_tap_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (jj_reg <= two_k))
        else $error("tap counter ran past 2K");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.smoothed_ok) |-> (out_data_reg.smoothed == '0))
        else $error("invalid result carries a nonzero value");

    a_accept_plans: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_PLAN))
        else $error("accepted transaction not planned");

endmodule

FILE: design/mssm_window.sv
// Reading window: shift line of recent rays, first ray of the scan, ray counter.
module mssm_window
    import mssm_pkg::*;
#(
    parameter int MAX_NEIGHBOURS = 7,
    parameter int MAX_RAYS       = 4096,
    localparam int WIN_DEPTH = 2 * MAX_NEIGHBOURS + 1,
    localparam int IDX_W     = $clog2(WIN_DEPTH),
    localparam int POS_CAP   = (MAX_RAYS > WIN_DEPTH) ? MAX_RAYS : WIN_DEPTH,
    localparam int POS_W     = $clog2(POS_CAP + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  win_ctrl_t            ctrl,
    input  in_item_t             push_item,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic [READING_W-1:0] rd_value,
    output logic                 rd_ok,
    output logic [POS_W-1:0]     position
);

    logic [READING_W-1:0] values_reg [WIN_DEPTH];
    logic                 flags_reg  [WIN_DEPTH];
    logic [READING_W-1:0] first_value_reg;
    logic                 first_ok_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 use_first;

    // Value shift line, entry 0 newest
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            values_reg[0] <= push_item.reading;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                values_reg[i] <= values_reg[i-1];
            end
        end
    end

    // Valid flags, first ray and ray counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                flags_reg[i] <= 1'b0;
            end
            first_ok_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                flags_reg[0] <= push_item.reading_ok;
                for (int i = 1; i < WIN_DEPTH; i++)
                begin
                    flags_reg[i] <= flags_reg[i-1];
                end
            end
            if (ctrl.restart)
            begin
                first_ok_reg <= 1'b0;
                pos_reg      <= '0;
            end
            else if (ctrl.push)
            begin
                if (pos_reg == '0)
                begin
                    first_ok_reg <= push_item.reading_ok;
                end
                if (pos_reg < POS_W'(POS_CAP))
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.restart && pos_reg == '0)
        begin
            first_value_reg <= push_item.reading;
        end
    end

    // Read port: positions older than the scan's first ray fall back to it
    assign use_first = (POS_W'(rd_idx) >= pos_reg) || (32'(rd_idx) >= WIN_DEPTH);

    always_comb
    begin
        if (use_first)
        begin
            rd_value = first_value_reg;
            rd_ok    = first_ok_reg;
        end
        else
        begin
            rd_value = values_reg[rd_idx];
            rd_ok    = flags_reg[rd_idx];
        end
    end

    assign position = pos_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.restart |=> (pos_reg == '0 && !first_ok_reg))
        else $error("window restart did not clear the ray counter");

    a_pos_capped: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(POS_CAP))
        else $error("ray counter beyond its cap");

endmodule

FILE: design/mssm_mac.sv
// Shared multiply-accumulate unit with rounding and 24-bit saturation.
module mssm_mac
    import mssm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mac_ctrl_t            ctrl,
    input  logic [READING_W-1:0] operand,
    input  logic [TAP_W-1:0]     tap,
    output logic [READING_W-1:0] result
);

    logic [PROD_W-1:0]        prod_reg;
    logic                     prod_vld_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W:0]           rounded;
    logic [ACC_W-TAP_W:0]     scaled;

    // Product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= operand * tap;
        end
    end

    // Accumulate stage
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round half up, drop the Q0.16 fraction, saturate
    assign rounded = {1'b0, acc_reg} + {1'b0, ROUND_BIAS};
    assign scaled  = rounded[ACC_W:TAP_W];
    assign result  = (|scaled[ACC_W-TAP_W:READING_W]) ? {READING_W{1'b1}}
                                                     : scaled[READING_W-1:0];

endmodule
